FILE: rtl/rrtr_pkg.sv
// ----------------------------------------------------------------------------
// rrtr_pkg: shared types and constants for the round-robin thread ring
// Slot geometry, operation and result codes, sequencer states and the
// lowest-free-slot search used when a thread is created.
// ----------------------------------------------------------------------------
package rrtr_pkg;

  // Slot geometry.
  localparam int MAX_THREADS = 16;
  localparam int SLOT_W      = $clog2(MAX_THREADS);
  localparam int COUNT_W     = $clog2(MAX_THREADS + 1);

  // Payload geometry: one context is status, pc and stack, 32 bits each.
  localparam int WORD_W   = 32;
  localparam int CTX_W    = 3 * WORD_W;
  localparam int S_DATA_W = CTX_W;
  localparam int M_DATA_W = ((SLOT_W + CTX_W + 7) / 8) * 8;
  localparam int PAD_W    = M_DATA_W - SLOT_W - CTX_W;

  // Request kinds carried on the input tuser.
  typedef enum logic [1:0] {
    OP_SWITCH = 2'd0,
    OP_CREATE = 2'd1,
    OP_FINISH = 2'd2
  } opcode_t;

  // Result codes carried on the output tuser.
  typedef enum logic [1:0] {
    RC_OK        = 2'd0,
    RC_BUSY      = 2'd1,
    RC_NO_SLOT   = 2'd2,
    RC_NO_THREAD = 2'd3
  } res_code_t;

  // Sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ADV,
    ST_SPLICE,
    ST_SPLICE2,
    ST_UNL_RD,
    ST_UNL_WR,
    ST_DONE
  } state_t;

  // Lowest set bit of the free map; the caller checks that one is set.
  function automatic logic [SLOT_W-1:0] first_free(input logic [MAX_THREADS-1:0] map);
    logic [SLOT_W-1:0] idx;
    idx = '0;
    for (int i = MAX_THREADS - 1; i >= 0; i--) begin
      if (map[i]) begin
        idx = SLOT_W'(i);
      end
    end
    return idx;
  endfunction

endpackage

FILE: rtl/round_robin_thread_ring.sv
// ----------------------------------------------------------------------------
// round_robin_thread_ring: hardware thread-context scheduler
// Create and finish requests pass from accept through ST_DONE to the result;
// a switch first runs the serial read-modify-write of the link RAMs
// (advance, splice of a new thread, unlink of a finished one).
// One request is in flight at a time; a result waits in the output register
// while the next request is accepted. Synchronous reset: all slots free, no
// thread linked, boot mode set, no pending create or finish.
// ----------------------------------------------------------------------------
module round_robin_thread_ring
  import rrtr_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  // Request channel.
  input  logic                s_tvalid,
  output logic                s_tready,
  input  logic [S_DATA_W-1:0] s_tdata,   // status_word, resume_pc, stack_pointer
  input  logic [1:0]          s_tuser,   // opcode
  // Result channel.
  output logic                m_tvalid,
  input  logic                m_tready,
  output logic [M_DATA_W-1:0] m_tdata,   // slot_id, restore_status, restore_pc,
                                         // restore_stack, zero pad
  output logic [1:0]          m_tuser    // result_code
);

  // Scheduler state.
  state_t                 state, state_next;
  logic [MAX_THREADS-1:0] free_map, free_map_next;
  logic [SLOT_W-1:0]      active_slot, active_slot_next;
  logic                   boot_mode, boot_mode_next;
  logic                   new_valid, new_valid_next;
  logic [SLOT_W-1:0]      pending_new, pending_new_next;
  logic                   finish_valid, finish_valid_next;
  logic [SLOT_W-1:0]      pending_finish, pending_finish_next;
  logic                   dead_valid, dead_valid_next;
  logic [SLOT_W-1:0]      dead_slot, dead_slot_next;
  logic [COUNT_W-1:0]     linked_count, linked_count_next;
  logic [SLOT_W-1:0]      link_b, link_b_next;

  // Result held for the output stage.
  res_code_t              res_code, res_code_next;
  logic [SLOT_W-1:0]      res_slot, res_slot_next;
  logic                   res_restore, res_restore_next;

  // Output register.
  logic                   out_valid, out_valid_next;
  res_code_t              out_code, out_code_next;
  logic [SLOT_W-1:0]      out_slot, out_slot_next;
  logic [CTX_W-1:0]       out_ctx, out_ctx_next;

  // Memory ports.
  logic                   ctx_we, ctx_re;
  logic [SLOT_W-1:0]      ctx_waddr, ctx_raddr;
  logic [CTX_W-1:0]       ctx_rdata;
  logic                   nxt_we, nxt_re;
  logic [SLOT_W-1:0]      nxt_waddr, nxt_wdata, nxt_raddr, nxt_rdata;
  logic                   prv_we, prv_re;
  logic [SLOT_W-1:0]      prv_waddr, prv_wdata, prv_raddr, prv_rdata;

  logic                   out_free;
  opcode_t                op;

  assign op       = opcode_t'(s_tuser);
  assign out_free = !out_valid || m_tready;

  // Saved contexts: status in the low word, then pc, then stack pointer.
  rrtr_ram #(.WIDTH(CTX_W), .DEPTH(MAX_THREADS)) u_ctx_ram (
    .clk   (clk),
    .we    (ctx_we),
    .waddr (ctx_waddr),
    .wdata (s_tdata),
    .re    (ctx_re),
    .raddr (ctx_raddr),
    .rdata (ctx_rdata)
  );

  // Forward links of the ring.
  rrtr_ram #(.WIDTH(SLOT_W), .DEPTH(MAX_THREADS)) u_next_ram (
    .clk   (clk),
    .we    (nxt_we),
    .waddr (nxt_waddr),
    .wdata (nxt_wdata),
    .re    (nxt_re),
    .raddr (nxt_raddr),
    .rdata (nxt_rdata)
  );

  // Backward links of the ring.
  rrtr_ram #(.WIDTH(SLOT_W), .DEPTH(MAX_THREADS)) u_prev_ram (
    .clk   (clk),
    .we    (prv_we),
    .waddr (prv_waddr),
    .wdata (prv_wdata),
    .re    (prv_re),
    .raddr (prv_raddr),
    .rdata (prv_rdata)
  );

  // State registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      free_map     <= '1;
      active_slot  <= '0;
      boot_mode    <= 1'b1;
      new_valid    <= 1'b0;
      finish_valid <= 1'b0;
      dead_valid   <= 1'b0;
      linked_count <= '0;
      out_valid    <= 1'b0;
    end else begin
      state        <= state_next;
      free_map     <= free_map_next;
      active_slot  <= active_slot_next;
      boot_mode    <= boot_mode_next;
      new_valid    <= new_valid_next;
      finish_valid <= finish_valid_next;
      dead_valid   <= dead_valid_next;
      linked_count <= linked_count_next;
      out_valid    <= out_valid_next;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    pending_new    <= pending_new_next;
    pending_finish <= pending_finish_next;
    dead_slot      <= dead_slot_next;
    link_b         <= link_b_next;
    res_code       <= res_code_next;
    res_slot       <= res_slot_next;
    res_restore    <= res_restore_next;
    out_code       <= out_code_next;
    out_slot       <= out_slot_next;
    out_ctx        <= out_ctx_next;
  end

  // Sequencer: next state, state updates and memory accesses.
  always_comb begin
    state_next          = state;
    free_map_next       = free_map;
    active_slot_next    = active_slot;
    boot_mode_next      = boot_mode;
    new_valid_next      = new_valid;
    pending_new_next    = pending_new;
    finish_valid_next   = finish_valid;
    pending_finish_next = pending_finish;
    dead_valid_next     = dead_valid;
    dead_slot_next      = dead_slot;
    linked_count_next   = linked_count;
    link_b_next         = link_b;
    res_code_next       = res_code;
    res_slot_next       = res_slot;
    res_restore_next    = res_restore;
    out_valid_next      = out_valid && !m_tready;
    out_code_next       = out_code;
    out_slot_next       = out_slot;
    out_ctx_next        = out_ctx;
    s_tready            = 1'b0;
    ctx_we              = 1'b0;
    ctx_waddr           = active_slot;
    ctx_re              = 1'b0;
    ctx_raddr           = active_slot;
    nxt_we              = 1'b0;
    nxt_waddr           = active_slot;
    nxt_wdata           = active_slot;
    nxt_re              = 1'b0;
    nxt_raddr           = active_slot;
    prv_we              = 1'b0;
    prv_waddr           = active_slot;
    prv_wdata           = active_slot;
    prv_re              = 1'b0;
    prv_raddr           = pending_finish;

    case (state)
      ST_IDLE: begin
        s_tready         = 1'b1;
        res_code_next    = RC_OK;
        res_slot_next    = '0;
        res_restore_next = 1'b0;
        if (s_tvalid) begin
          state_next = ST_DONE;
          case (op)
            OP_SWITCH: begin
              // The slot unlinked by the previous switch becomes free now.
              if (dead_valid) begin
                free_map_next[dead_slot] = 1'b1;
                dead_valid_next          = 1'b0;
              end
              if (linked_count == '0) begin
                res_code_next = RC_NO_THREAD;
              end else if (boot_mode) begin
                // First entry: nothing to save, the head slot runs.
                boot_mode_next = 1'b0;
                nxt_re         = 1'b1;
                ctx_re         = 1'b1;
                state_next     = ST_SPLICE;
              end else begin
                // Save the outgoing context and fetch its successor.
                ctx_we     = 1'b1;
                nxt_re     = 1'b1;
                state_next = ST_ADV;
              end
            end
            OP_CREATE: begin
              if (new_valid) begin
                res_code_next = RC_BUSY;
              end else if (free_map == '0) begin
                res_code_next = RC_NO_SLOT;
              end else begin
                free_map_next[first_free(free_map)] = 1'b0;
                ctx_we        = 1'b1;
                ctx_waddr     = first_free(free_map);
                res_slot_next = first_free(free_map);
                if (linked_count == '0) begin
                  // Empty ring: the new slot links to itself and runs next.
                  nxt_we            = 1'b1;
                  nxt_waddr         = first_free(free_map);
                  nxt_wdata         = first_free(free_map);
                  prv_we            = 1'b1;
                  prv_waddr         = first_free(free_map);
                  prv_wdata         = first_free(free_map);
                  active_slot_next  = first_free(free_map);
                  boot_mode_next    = 1'b1;
                  linked_count_next = COUNT_W'(1);
                end else begin
                  pending_new_next = first_free(free_map);
                  new_valid_next   = 1'b1;
                end
              end
            end
            OP_FINISH: begin
              if (boot_mode || linked_count == '0 ||
                  (dead_valid && dead_slot == active_slot)) begin
                res_code_next = RC_NO_THREAD;
              end else if (finish_valid) begin
                res_code_next = RC_BUSY;
              end else begin
                pending_finish_next = active_slot;
                finish_valid_next   = 1'b1;
                res_slot_next       = active_slot;
              end
            end
            default: begin
              res_code_next = RC_OK;
            end
          endcase
        end
      end

      // Step to the successor and start reading its link and context.
      ST_ADV: begin
        active_slot_next = nxt_rdata;
        nxt_re           = 1'b1;
        nxt_raddr        = nxt_rdata;
        ctx_re           = 1'b1;
        ctx_raddr        = nxt_rdata;
        state_next       = ST_SPLICE;
      end

      // Link the pending new slot in after the active one, first half; with none pending, start the unlink or finish.
      ST_SPLICE: begin
        if (new_valid) begin
          link_b_next = nxt_rdata;
          nxt_we      = 1'b1;
          nxt_waddr   = pending_new;
          nxt_wdata   = nxt_rdata;
          prv_we      = 1'b1;
          prv_waddr   = pending_new;
          prv_wdata   = active_slot;
          state_next  = ST_SPLICE2;
        end else if (finish_valid) begin
          nxt_re     = 1'b1;
          nxt_raddr  = pending_finish;
          prv_re     = 1'b1;
          state_next = ST_UNL_WR;
        end else begin
          res_code_next    = RC_OK;
          res_slot_next    = active_slot;
          res_restore_next = 1'b1;
          state_next       = ST_DONE;
        end
      end

      // Second half of the splice: neighbors point at the new slot.
      ST_SPLICE2: begin
        nxt_we            = 1'b1;
        nxt_waddr         = active_slot;
        nxt_wdata         = pending_new;
        prv_we            = 1'b1;
        prv_waddr         = link_b;
        prv_wdata         = pending_new;
        new_valid_next    = 1'b0;
        linked_count_next = linked_count + COUNT_W'(1);
        if (finish_valid) begin
          state_next = ST_UNL_RD;
        end else begin
          res_code_next    = RC_OK;
          res_slot_next    = active_slot;
          res_restore_next = 1'b1;
          state_next       = ST_DONE;
        end
      end

      // Read both links of the finished slot after the splice has landed.
      ST_UNL_RD: begin
        nxt_re     = 1'b1;
        nxt_raddr  = pending_finish;
        prv_re     = 1'b1;
        state_next = ST_UNL_WR;
      end

      // Bridge the finished slot's neighbors over it.
      ST_UNL_WR: begin
        nxt_we            = 1'b1;
        nxt_waddr         = prv_rdata;
        nxt_wdata         = nxt_rdata;
        prv_we            = 1'b1;
        prv_waddr         = nxt_rdata;
        prv_wdata         = prv_rdata;
        dead_slot_next    = pending_finish;
        dead_valid_next   = 1'b1;
        finish_valid_next = 1'b0;
        linked_count_next = linked_count - COUNT_W'(1);
        res_code_next     = RC_OK;
        res_slot_next     = active_slot;
        res_restore_next  = 1'b1;
        state_next        = ST_DONE;
      end

      // Hand the result to the output register once it is free.
      ST_DONE: begin
        if (out_free) begin
          out_valid_next = 1'b1;
          out_code_next  = res_code;
          out_slot_next  = res_slot;
          out_ctx_next   = res_restore ? ctx_rdata : '0;
          state_next     = ST_IDLE;
        end
      end

      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Output channel.
  assign m_tvalid = out_valid;
  assign m_tuser  = out_code;
  assign m_tdata  = {{PAD_W{1'b0}}, out_ctx, out_slot};

`ifndef SYNTHESIS
  // A pending new thread only exists while the ring is populated.
  a_new_needs_ring: assert property (@(posedge clk) disable iff (rst)
    new_valid |-> linked_count != '0)
    else $error("pending new thread with an empty ring");

  // The pending new slot must stay allocated until it is spliced in.
  a_new_not_free: assert property (@(posedge clk) disable iff (rst)
    new_valid |-> !free_map[pending_new])
    else $error("pending new slot is marked free");

  // An unlinked slot must not return to the free map before the next switch.
  a_dead_not_free: assert property (@(posedge clk) disable iff (rst)
    dead_valid |-> !free_map[dead_slot])
    else $error("unlinked slot freed too early");

  // The ring never holds more threads than there are slots.
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    linked_count <= COUNT_W'(MAX_THREADS))
    else $error("linked slot count out of range");

  // A finished request reaches the output register in the next cycle.
  a_done_delivers: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DONE && out_free) |=> (m_tvalid && state == ST_IDLE))
    else $error("result not loaded into the output register");
`endif

endmodule

FILE: rtl/rrtr_ram.sv
// ----------------------------------------------------------------------------
// rrtr_ram: generic single-write, single-read synchronous RAM
// One write port and one read port; read data is registered and holds its
// value until the next read. A read of the address being written returns
// the old contents.
// ----------------------------------------------------------------------------
module rrtr_ram #(
  parameter int WIDTH  = 8,
  parameter int DEPTH  = 16,
  localparam int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: dv/round_robin_thread_ring_checker.sv
// ----------------------------------------------------------------------------
// round_robin_thread_ring_checker: scoreboard for the thread ring scheduler
// Watches both stream channels, keeps its own copy of the ring (links, saved
// contexts, free slots, pending create/finish, slot awaiting release) and
// checks every result against the outcome of its accepted request, in order.
// ----------------------------------------------------------------------------
module round_robin_thread_ring_checker
  import rrtr_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                s_tvalid,
  input  logic                s_tready,
  input  logic [S_DATA_W-1:0] s_tdata,   // status_word, resume_pc, stack_pointer
  input  logic [1:0]          s_tuser,   // opcode
  input  logic                m_tvalid,
  input  logic                m_tready,
  input  logic [M_DATA_W-1:0] m_tdata,   // slot_id, restore_status, restore_pc,
                                         // restore_stack, zero pad
  input  logic [1:0]          m_tuser,   // result_code
  output int                  errors,
  output int                  due_count
);

  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_REPORTS = 200;

  typedef struct packed {
    res_code_t         code;
    logic [SLOT_W-1:0] slot;
    logic [WORD_W-1:0] status;
    logic [WORD_W-1:0] pc;
    logic [WORD_W-1:0] stack;
  } sched_result_t;

  // Shadow copy of the scheduler state.
  logic [WORD_W-1:0] saved_status [MAX_THREADS];
  logic [WORD_W-1:0] saved_pc     [MAX_THREADS];
  logic [WORD_W-1:0] saved_stack  [MAX_THREADS];
  logic [SLOT_W-1:0] ring_next    [MAX_THREADS];
  logic [SLOT_W-1:0] ring_prev    [MAX_THREADS];
  logic [MAX_THREADS-1:0] slot_free;
  logic [SLOT_W-1:0] running_slot;
  bit                booting;
  bit                create_pending;
  logic [SLOT_W-1:0] create_slot;
  bit                finish_pending;
  logic [SLOT_W-1:0] finish_slot;
  bit                release_pending;
  logic [SLOT_W-1:0] release_slot;
  int                ring_size;

  sched_result_t sched_results_due[$];
  int            result_no;

  initial begin
    errors    = 0;
    due_count = 0;
    result_no = 0;
  end

  // Applies one request to the shadow ring and returns the result it causes.
  function automatic sched_result_t next_sched_result(
    input logic [1:0]        op,
    input logic [WORD_W-1:0] st,
    input logic [WORD_W-1:0] pc,
    input logic [WORD_W-1:0] sp
  );
    sched_result_t     r;
    logic [SLOT_W-1:0] cur;
    logic [SLOT_W-1:0] gone;
    int                pick;
    r = '0;
    r.code = RC_OK;
    case (op)
      OP_SWITCH: begin
        // The slot unlinked by the previous switch goes back to the pool first.
        if (release_pending) begin
          slot_free[release_slot] = 1'b1;
          release_pending = 0;
        end
        if (ring_size == 0) begin
          r.code = RC_NO_THREAD;
          return r;
        end
        // Leaving boot mode saves nothing and stays on the ring head.
        if (booting) begin
          booting = 0;
        end else begin
          saved_status[running_slot] = st;
          saved_pc[running_slot]     = pc;
          saved_stack[running_slot]  = sp;
          running_slot = ring_next[running_slot];
        end
        cur = running_slot;
        // Splice a newly created thread right after the new active slot.
        if (create_pending) begin
          ring_next[create_slot]    = ring_next[cur];
          ring_prev[create_slot]    = cur;
          ring_prev[ring_next[cur]] = create_slot;
          ring_next[cur]            = create_slot;
          create_pending = 0;
          ring_size++;
        end
        // Unlink a finished thread unless a slot is still waiting for release.
        if (finish_pending && !release_pending) begin
          gone = finish_slot;
          ring_next[ring_prev[gone]] = ring_next[gone];
          ring_prev[ring_next[gone]] = ring_prev[gone];
          release_slot    = gone;
          release_pending = 1;
          finish_pending  = 0;
          ring_size--;
        end
        r.slot   = cur;
        r.status = saved_status[cur];
        r.pc     = saved_pc[cur];
        r.stack  = saved_stack[cur];
      end
      OP_CREATE: begin
        if (create_pending) begin
          r.code = RC_BUSY;
          return r;
        end
        pick = -1;
        for (int i = MAX_THREADS - 1; i >= 0; i--) begin
          if (slot_free[i]) begin
            pick = i;
          end
        end
        if (pick < 0) begin
          r.code = RC_NO_SLOT;
          return r;
        end
        slot_free[pick]    = 1'b0;
        saved_status[pick] = st;
        saved_pc[pick]     = pc;
        saved_stack[pick]  = sp;
        // The first thread of an empty ring forms a ring of its own at once.
        if (ring_size == 0) begin
          ring_next[pick] = SLOT_W'(pick);
          ring_prev[pick] = SLOT_W'(pick);
          running_slot    = SLOT_W'(pick);
          booting         = 1;
          ring_size       = 1;
        end else begin
          create_slot    = SLOT_W'(pick);
          create_pending = 1;
        end
        r.slot = SLOT_W'(pick);
      end
      OP_FINISH: begin
        if (booting || ring_size == 0 ||
            (release_pending && release_slot == running_slot)) begin
          r.code = RC_NO_THREAD;
          return r;
        end
        if (finish_pending) begin
          r.code = RC_BUSY;
          return r;
        end
        finish_slot    = running_slot;
        finish_pending = 1;
        r.slot         = running_slot;
      end
      default: begin
        // The unused opcode leaves everything alone and answers ok.
      end
    endcase
    return r;
  endfunction

  task automatic check_field(input string what, input logic [WORD_W-1:0] want_v,
                             input logic [WORD_W-1:0] got_v);
    if (got_v !== want_v) begin
      errors++;
      if (errors <= MAX_REPORTS) begin
        $display("%0t ns: result %0d %s mismatch, expected 0x%0h, got 0x%0h",
                 $time, result_no, what, want_v, got_v);
      end
    end
  endtask

  // Predict on each accepted request, compare on each accepted result.
  always @(posedge clk) begin
    sched_result_t got;
    sched_result_t want;
    if (rst) begin
      for (int i = 0; i < MAX_THREADS; i++) begin
        saved_status[i] = '0;
        saved_pc[i]     = '0;
        saved_stack[i]  = '0;
        ring_next[i]    = '0;
        ring_prev[i]    = '0;
      end
      slot_free       = '1;
      running_slot    = '0;
      booting         = 1;
      create_pending  = 0;
      create_slot     = '0;
      finish_pending  = 0;
      finish_slot     = '0;
      release_pending = 0;
      release_slot    = '0;
      ring_size       = 0;
      sched_results_due.delete();
    end else begin
      if (s_tvalid && s_tready) begin
        sched_results_due.push_back(next_sched_result(
          s_tuser, s_tdata[0 +: WORD_W], s_tdata[WORD_W +: WORD_W],
          s_tdata[2*WORD_W +: WORD_W]));
      end
      if (m_tvalid && m_tready) begin
        got.code   = res_code_t'(m_tuser);
        got.slot   = m_tdata[0 +: SLOT_W];
        got.status = m_tdata[SLOT_W +: WORD_W];
        got.pc     = m_tdata[SLOT_W + WORD_W +: WORD_W];
        got.stack  = m_tdata[SLOT_W + 2*WORD_W +: WORD_W];
        if (sched_results_due.size() == 0) begin
          errors++;
          if (errors <= MAX_REPORTS) begin
            $display("%0t ns: unexpected result, expected none, got code %0d slot %0d",
                     $time, got.code, got.slot);
          end
        end else begin
          want = sched_results_due.pop_front();
          check_field("result_code", WORD_W'(want.code), WORD_W'(got.code));
          check_field("slot_id", WORD_W'(want.slot), WORD_W'(got.slot));
          check_field("restore_status", want.status, got.status);
          check_field("restore_pc", want.pc, got.pc);
          check_field("restore_stack", want.stack, got.stack);
        end
        result_no++;
      end
    end
    due_count <= sched_results_due.size();
  end

endmodule

FILE: dv/round_robin_thread_ring_test.sv
// ----------------------------------------------------------------------------
// round_robin_thread_ring_test: testbench top for the thread ring scheduler
// Drives a directed walk through the boot, busy, empty-ring and self-unlink
// corners, then random runs that grow, churn and shrink the ring, with random
// gaps on both channels. The checker beside the block scores every result.
// ----------------------------------------------------------------------------
module round_robin_thread_ring_test;

  timeunit 1ns;
  timeprecision 1ps;

  import rrtr_pkg::*;

  localparam logic [1:0] OP_RESERVED = 2'd3;
  localparam int RAND_ITEMS  = 950;
  localparam int MAX_IDLE    = 11;
  localparam int TIMEOUT_NS  = 10_000_000;

  typedef enum int {
    MIX_GROW,
    MIX_CHURN,
    MIX_SHRINK
  } mix_t;

  logic                clk      = 1'b0;
  logic                rst      = 1'b1;
  logic                s_tvalid = 1'b0;
  logic                s_tready;
  logic [S_DATA_W-1:0] s_tdata  = '0;
  logic [1:0]          s_tuser  = '0;
  logic                m_tvalid;
  logic                m_tready = 1'b0;
  logic [M_DATA_W-1:0] m_tdata;
  logic [1:0]          m_tuser;
  int                  errors;
  int                  due_count;
  bit                  tx_steady = 0;

  always #10 clk = ~clk;

  round_robin_thread_ring i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  round_robin_thread_ring_checker i_checker (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .errors    (errors),
    .due_count (due_count)
  );

  // Context words lean on the extremes now and then.
  function automatic logic [WORD_W-1:0] rand_word();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      default: return $urandom;
    endcase
  endfunction

  // Operation mix per run: grow fills the ring, shrink empties it.
  function automatic logic [1:0] pick_op(input mix_t mix);
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 5) begin
      return OP_RESERVED;
    end
    case (mix)
      MIX_GROW:   return (roll < 50) ? OP_CREATE : (roll < 95) ? OP_SWITCH : OP_FINISH;
      MIX_SHRINK: return (roll < 50) ? OP_FINISH : (roll < 95) ? OP_SWITCH : OP_CREATE;
      default:    return (roll < 25) ? OP_CREATE : (roll < 70) ? OP_SWITCH : OP_FINISH;
    endcase
  endfunction

  // One request, after a random gap unless the sender runs back to back.
  task automatic send_request(input logic [1:0] op, input logic [WORD_W-1:0] st,
                              input logic [WORD_W-1:0] pc,
                              input logic [WORD_W-1:0] sp);
    int unsigned gap;
    gap = tx_steady ? 0 : $urandom_range(0, MAX_IDLE);
    if (gap != 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tdata  <= {sp, pc, st};
    do @(posedge clk); while (!s_tready);
  endtask

  // Hold off the sender until every result owed has been taken.
  task automatic wait_drained();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (due_count != 0);
  endtask

  // Result side: random stalls, with back-to-back stretches.
  initial begin
    int unsigned stall;
    int unsigned taken;
    bit          rx_steady;
    taken     = 0;
    rx_steady = 0;
    do @(posedge clk); while (rst);
    forever begin
      if (taken % 32 == 0) begin
        rx_steady = ($urandom_range(0, 3) == 0);
      end
      stall = rx_steady ? 0 : $urandom_range(0, MAX_IDLE);
      if (stall != 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!m_tvalid);
      taken++;
    end
  end

  // Stimulus and verdict.
  initial begin
    int unsigned sent;
    int unsigned run_len;
    mix_t        mix;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Empty ring, unused opcode, then a first thread in boot mode.
    send_request(OP_SWITCH, '1, '1, '1);
    send_request(OP_FINISH, '0, '0, '0);
    send_request(OP_RESERVED, '1, '1, '1);
    send_request(OP_CREATE, '0, '0, '0);
    send_request(OP_FINISH, rand_word(), rand_word(), rand_word());
    // A second create is pending, so a third one is busy.
    send_request(OP_CREATE, '1, '1, '1);
    send_request(OP_CREATE, rand_word(), rand_word(), rand_word());
    // Boot entry splices the pending thread; a second finish is busy.
    send_request(OP_SWITCH, rand_word(), rand_word(), rand_word());
    send_request(OP_FINISH, '0, '0, '0);
    send_request(OP_FINISH, '0, '0, '0);
    send_request(OP_SWITCH, '1, '1, '1);
    // Unlinking the last slot still restores its own context.
    send_request(OP_FINISH, '0, '0, '0);
    send_request(OP_SWITCH, 32'h0123_4567, 32'h89ab_cdef, 32'hfedc_ba98);
    send_request(OP_SWITCH, '0, '0, '0);
    send_request(OP_FINISH, '1, '1, '1);
    // New ring; finishing a lone thread while a create is pending leaves the
    // active slot unlinked, so a further finish has no thread.
    send_request(OP_CREATE, rand_word(), rand_word(), rand_word());
    send_request(OP_SWITCH, rand_word(), rand_word(), rand_word());
    send_request(OP_CREATE, rand_word(), rand_word(), rand_word());
    send_request(OP_FINISH, '0, '0, '0);
    send_request(OP_SWITCH, rand_word(), rand_word(), rand_word());
    send_request(OP_FINISH, '0, '0, '0);
    send_request(OP_SWITCH, rand_word(), rand_word(), rand_word());
    send_request(OP_SWITCH, rand_word(), rand_word(), rand_word());
    wait_drained();

    // Random runs, each with its own operation mix and sender pace.
    sent = 0;
    while (sent < RAND_ITEMS) begin
      mix       = mix_t'($urandom_range(0, 2));
      run_len   = $urandom_range(20, 60);
      tx_steady = ($urandom_range(0, 3) == 0);
      repeat (run_len) begin
        send_request(pick_op(mix), rand_word(), rand_word(), rand_word());
        sent++;
      end
      if ($urandom_range(0, 3) == 0) begin
        wait_drained();
      end
    end

    wait_drained();
    repeat (16) @(posedge clk);
    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // Watchdog.
  initial begin
    #TIMEOUT_NS;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule

FILE: sim.f
rtl/rrtr_pkg.sv
rtl/rrtr_ram.sv
rtl/round_robin_thread_ring.sv
dv/round_robin_thread_ring_checker.sv
dv/round_robin_thread_ring_test.sv
